@@ src/srd_pkg.sv @@
// ----------------------------------------------------------------------------
// srd_pkg: shared definitions of the scale report deframer
// Frame marker bytes, header slots, report codes, the CRC-16/MODBUS byte
// update and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

    // Largest payload byte count accepted in a frame header
    localparam int MAX_PAYLOAD = 64;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int LEN_W       = 16;

    // Frame marker bytes
    localparam logic [7:0] MARK_FIRST  = 8'hA5;
    localparam logic [7:0] MARK_SECOND = 8'h5A;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Header store slots
    localparam logic [2:0] HDR_MARK0 = 3'd0;
    localparam logic [2:0] HDR_MARK1 = 3'd1;
    localparam logic [2:0] HDR_CLASS = 3'd2;
    localparam logic [2:0] HDR_TYPE  = 3'd3;
    localparam logic [2:0] HDR_LENH  = 3'd4;
    localparam logic [2:0] HDR_LENL  = 3'd5;
    localparam int         HDR_DEPTH = 6;

    // Report decoding
    localparam logic [7:0] CLASS_A      = 8'h01;
    localparam logic [7:0] CLASS_B      = 8'h02;
    localparam logic [7:0] TYPE_WEIGHT  = 8'h01;
    localparam logic [7:0] TYPE_BATTERY = 8'h05;
    localparam logic [LEN_W-1:0] MIN_WEIGHT_LEN  = 16'd8;
    localparam logic [LEN_W-1:0] MIN_BATTERY_LEN = 16'd2;

    typedef enum logic [1:0] {
        KIND_OTHER   = 2'd0,
        KIND_WEIGHT  = 2'd1,
        KIND_BATTERY = 2'd2
    } srd_kind_t;

    // Running CRC operations
    typedef enum logic [1:0] {
        CRC_HOLD    = 2'd0,
        CRC_CLEAR   = 2'd1,
        CRC_RESTART = 2'd2,
        CRC_UPDATE  = 2'd3
    } srd_crc_op_t;

    // Payload byte counter operations
    typedef enum logic [1:0] {
        CNT_HOLD  = 2'd0,
        CNT_CLEAR = 2'd1,
        CNT_INC   = 2'd2
    } srd_cnt_op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic        replay_sel;
        logic [1:0]  replay_idx;
        logic        replay_load;
        logic        hdr_wr;
        logic [2:0]  hdr_idx;
        srd_crc_op_t crc_op;
        srd_cnt_op_t cnt_op;
        logic        pay_clear;
        logic        pay_take;
        logic        rcv_hi;
        logic        emit;
    } srd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic eq_first;
        logic eq_second;
        logic len_too_big;
        logic len_zero;
        logic cnt_last;
        logic out_full;
    } srd_stat_t;

    // Fold one byte into the CRC, LSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/srd_ctrl.sv @@
// ----------------------------------------------------------------------------
// srd_ctrl: frame parser controller
// Tracks the frame phase, sequences header rescans after an oversize length
// and issues per-byte commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_ctrl import srd_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire srd_stat_t stat,
    output srd_cmd_t       cmd
);

    typedef enum logic [8:0] {
        ST_HUNT    = 9'b000000001,
        ST_MARK    = 9'b000000010,
        ST_CLASS   = 9'b000000100,
        ST_TYPE    = 9'b000001000,
        ST_LENH    = 9'b000010000,
        ST_LENL    = 9'b000100000,
        ST_PAYLOAD = 9'b001000000,
        ST_CRC_HI  = 9'b010000000,
        ST_CRC_LO  = 9'b100000000
    } srd_state_t;

    srd_state_t state_reg, state_next;
    logic       replay_busy_reg, replay_busy_next;
    logic [1:0] replay_idx_reg, replay_idx_next;
    logic       step;

    // Stall requests while replaying or when a result would hit a full output
    assign s_ready = ~replay_busy_reg & ~((state_reg == ST_CRC_LO) & stat.out_full);
    assign step    = (s_valid & s_ready) | replay_busy_reg;

    // Decode phase and byte into commands
    always_comb begin
        state_next = state_reg;
        cmd             = '0;
        cmd.crc_op      = CRC_HOLD;
        cmd.cnt_op      = CNT_HOLD;
        cmd.replay_sel  = replay_busy_reg;
        cmd.replay_idx  = replay_idx_reg;
        if (step) begin
            case (state_reg)
                ST_HUNT: begin
                    if (stat.eq_first) begin
                        cmd.hdr_wr  = 1'b1;
                        cmd.hdr_idx = HDR_MARK0;
                        cmd.crc_op  = CRC_RESTART;
                        state_next  = ST_MARK;
                    end
                end
                ST_MARK: begin
                    if (stat.eq_second) begin
                        cmd.hdr_wr  = 1'b1;
                        cmd.hdr_idx = HDR_MARK1;
                        cmd.crc_op  = CRC_UPDATE;
                        state_next  = ST_CLASS;
                    end else if (stat.eq_first) begin
                        cmd.hdr_wr  = 1'b1;
                        cmd.hdr_idx = HDR_MARK0;
                        cmd.crc_op  = CRC_RESTART;
                    end else begin
                        cmd.crc_op = CRC_CLEAR;
                        cmd.cnt_op = CNT_CLEAR;
                        state_next = ST_HUNT;
                    end
                end
                ST_CLASS: begin
                    cmd.hdr_wr  = 1'b1;
                    cmd.hdr_idx = HDR_CLASS;
                    cmd.crc_op  = CRC_UPDATE;
                    state_next  = ST_TYPE;
                end
                ST_TYPE: begin
                    cmd.hdr_wr  = 1'b1;
                    cmd.hdr_idx = HDR_TYPE;
                    cmd.crc_op  = CRC_UPDATE;
                    state_next  = ST_LENH;
                end
                ST_LENH: begin
                    cmd.hdr_wr  = 1'b1;
                    cmd.hdr_idx = HDR_LENH;
                    cmd.crc_op  = CRC_UPDATE;
                    state_next  = ST_LENL;
                end
                ST_LENL: begin
                    cmd.hdr_wr  = 1'b1;
                    cmd.hdr_idx = HDR_LENL;
                    cmd.cnt_op  = CNT_CLEAR;
                    if (stat.len_too_big) begin
                        // drop both marker bytes and rescan the rest
                        cmd.crc_op      = CRC_CLEAR;
                        cmd.replay_load = 1'b1;
                        state_next      = ST_HUNT;
                    end else begin
                        cmd.crc_op    = CRC_UPDATE;
                        cmd.pay_clear = 1'b1;
                        state_next    = stat.len_zero ? ST_CRC_HI : ST_PAYLOAD;
                    end
                end
                ST_PAYLOAD: begin
                    cmd.crc_op   = CRC_UPDATE;
                    cmd.pay_take = 1'b1;
                    if (stat.cnt_last) begin
                        cmd.cnt_op = CNT_CLEAR;
                        state_next = ST_CRC_HI;
                    end else begin
                        cmd.cnt_op = CNT_INC;
                    end
                end
                ST_CRC_HI: begin
                    cmd.rcv_hi = 1'b1;
                    state_next = ST_CRC_LO;
                end
                ST_CRC_LO: begin
                    cmd.emit   = 1'b1;
                    cmd.crc_op = CRC_CLEAR;
                    cmd.cnt_op = CNT_CLEAR;
                    state_next = ST_HUNT;
                end
                default: begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    // Advance the rescan pointer over the four saved header bytes
    always_comb begin
        replay_busy_next = replay_busy_reg;
        replay_idx_next  = replay_idx_reg;
        if (cmd.replay_load) begin
            replay_busy_next = 1'b1;
            replay_idx_next  = '0;
        end else if (replay_busy_reg) begin
            replay_idx_next = replay_idx_reg + 2'd1;
            if (replay_idx_reg == 2'd3) begin
                replay_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_HUNT;
            replay_busy_reg <= 1'b0;
            replay_idx_reg  <= '0;
        end else begin
            state_reg       <= state_next;
            replay_busy_reg <= replay_busy_next;
            replay_idx_reg  <= replay_idx_next;
        end
    end

endmodule

`default_nettype wire

@@ src/srd_datapath.sv @@
// ----------------------------------------------------------------------------
// srd_datapath: frame parser datapath
// Holds the header store, running CRC, payload counter, report bytes, the
// rescan buffer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_datapath import srd_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [7:0]   s_rx_byte,
    input  wire srd_cmd_t     cmd,
    output srd_stat_t         stat,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [7:0]        m_frame_class,
    output logic [7:0]        m_frame_type,
    output logic [6:0]        m_payload_length,
    output logic              m_crc_ok,
    output logic [1:0]        m_report_kind,
    output logic signed [31:0] m_weight_tenths,
    output logic [7:0]        m_battery_percent
);

    logic [7:0]       hdr_reg [HDR_DEPTH];
    logic [7:0]       replay_reg [4];
    logic [15:0]      crc_reg, crc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       rcv_hi_reg;
    logic [31:0]      weight_reg;
    logic [7:0]       batt_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       rx;
    logic [LEN_W-1:0] len_new, len_stored;
    logic [7:0]       cls, typ;
    srd_kind_t        kind;

    // Select the live byte or a saved header byte during a rescan
    assign rx = cmd.replay_sel ? replay_reg[cmd.replay_idx] : s_rx_byte;

    assign len_new    = {hdr_reg[HDR_LENH], rx};
    assign len_stored = {hdr_reg[HDR_LENH], hdr_reg[HDR_LENL]};
    assign cls        = hdr_reg[HDR_CLASS];
    assign typ        = hdr_reg[HDR_TYPE];

    // Status to the controller
    always_comb begin
        stat.eq_first    = (rx == MARK_FIRST);
        stat.eq_second   = (rx == MARK_SECOND);
        stat.len_too_big = (len_new > LEN_W'(MAX_PAYLOAD));
        stat.len_zero    = (len_new == '0);
        stat.cnt_last    = ((LEN_W'(cnt_reg) + LEN_W'(1)) >= len_stored);
        stat.out_full    = out_valid_reg;
    end

    // Running CRC update
    always_comb begin
        case (cmd.crc_op)
            CRC_CLEAR:   crc_next = CRC_INIT;
            CRC_RESTART: crc_next = crc_feed(CRC_INIT, rx);
            CRC_UPDATE:  crc_next = crc_feed(crc_reg, rx);
            default:     crc_next = crc_reg;
        endcase
    end

    // Payload byte counter
    always_comb begin
        case (cmd.cnt_op)
            CNT_CLEAR: cnt_next = '0;
            CNT_INC:   cnt_next = cnt_reg + CNT_W'(1);
            default:   cnt_next = cnt_reg;
        endcase
    end

    // Decode the report kind from the stored header
    always_comb begin
        kind = KIND_OTHER;
        if (cls == CLASS_A || cls == CLASS_B) begin
            if (typ == TYPE_WEIGHT && len_stored >= MIN_WEIGHT_LEN) begin
                kind = KIND_WEIGHT;
            end else if (typ == TYPE_BATTERY && len_stored >= MIN_BATTERY_LEN) begin
                kind = KIND_BATTERY;
            end
        end
    end

    // Result handshake: drop on request taken, set on emit
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_INIT;
            cnt_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            crc_reg       <= crc_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Header store and rescan buffer
    always_ff @(posedge aclk) begin
        if (cmd.hdr_wr) begin
            hdr_reg[cmd.hdr_idx] <= rx;
        end
        if (cmd.replay_load) begin
            replay_reg[0] <= hdr_reg[HDR_CLASS];
            replay_reg[1] <= hdr_reg[HDR_TYPE];
            replay_reg[2] <= hdr_reg[HDR_LENH];
            replay_reg[3] <= rx;
        end
    end

    // Report bytes and received CRC high byte
    always_ff @(posedge aclk) begin
        if (cmd.pay_clear) begin
            weight_reg <= '0;
            batt_reg   <= '0;
        end else if (cmd.pay_take) begin
            if (cnt_reg < CNT_W'(4)) begin
                weight_reg <= {weight_reg[23:0], rx};
            end
            if (cnt_reg == CNT_W'(1)) begin
                batt_reg <= rx;
            end
        end
        if (cmd.rcv_hi) begin
            rcv_hi_reg <= rx;
        end
    end

    // Capture the result of a completed frame
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_frame_class     <= cls;
            m_frame_type      <= typ;
            m_payload_length  <= len_stored[6:0];
            m_crc_ok          <= (crc_reg == {rcv_hi_reg, rx});
            m_report_kind     <= kind;
            m_weight_tenths   <= (kind == KIND_WEIGHT) ? $signed(weight_reg) : 32'sd0;
            m_battery_percent <= (kind == KIND_BATTERY) ? batt_reg : 8'd0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ src/scale_report_deframer.sv @@
// ----------------------------------------------------------------------------
// scale_report_deframer: CRC-16/MODBUS framed report stream deframer
// Hunts for the A5 5A marker, parses class, type, length, payload and CRC,
// and returns one result per complete frame, decoding weight and battery reports.
// ----------------------------------------------------------------------------
//  Channel | Ports                     | Moves
//  --------+---------------------------+---------------------------------
//  s_      | s_valid/s_ready/s_rx_byte | one stream byte per request
//  m_      | m_valid/m_ready/m_*       | one frame result per request
//
//  One byte is taken per cycle while s_ready is high. A length above
//  MAX_PAYLOAD holds s_ready low while the saved header is replayed.
//  The last CRC byte is held off while an earlier result still sits in the
//  output register; other bytes keep flowing during an output stall.
//  Reset (aresetn low, synchronous) returns the parser to marker hunting.
// ----------------------------------------------------------------------------
`default_nettype none

module scale_report_deframer import srd_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_rx_byte,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_frame_class,
    output logic [7:0]         m_frame_type,
    output logic [6:0]         m_payload_length,
    output logic               m_crc_ok,
    output logic [1:0]         m_report_kind,
    output logic signed [31:0] m_weight_tenths,
    output logic [7:0]         m_battery_percent
);

    srd_cmd_t  cmd;
    srd_stat_t stat;

    // Phase sequencing
    srd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Byte handling and result register
    srd_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_rx_byte         (s_rx_byte),
        .cmd               (cmd),
        .stat              (stat),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_class     (m_frame_class),
        .m_frame_type      (m_frame_type),
        .m_payload_length  (m_payload_length),
        .m_crc_ok          (m_crc_ok),
        .m_report_kind     (m_report_kind),
        .m_weight_tenths   (m_weight_tenths),
        .m_battery_percent (m_battery_percent)
    );

endmodule

`default_nettype wire
